[design/ksa_pkg.sv]
// shared types and constants of the keyed slot allocator
package ksa_pkg;

  localparam int unsigned KEY_W        = 48;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned IDX_PER_QUAD = 6;

  // request codes, the last one unused and answered with an empty word
  typedef enum logic [2:0] {
    REQ_ALLOC    = 3'd0,
    REQ_FREE     = 3'd1,
    REQ_LOOKUP   = 3'd2,
    REQ_SETQ     = 3'd3,
    REQ_BUILD_OP = 3'd4,
    REQ_BUILD_TR = 3'd5,
    REQ_CLEAR    = 3'd6,
    REQ_RSVD     = 3'd7
  } req_e;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOKEY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // kinds of result word
  typedef enum logic [3:0] {
    EM_FOUND,
    EM_LOOKUP,
    EM_NEW,
    EM_FULL,
    EM_NOKEY,
    EM_BADIDX,
    EM_SETQ,
    EM_EMPTY,
    EM_CMD,
    EM_CMD_LAST
  } emit_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_FOUND,
    S_MISS,
    S_NEW,
    S_RESP,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic  load;
    logic  idx_inc;
    logic  rd;
    logic  pop_rd;
    logic  emit;
    emit_e kind;
    logic  alloc_hit;
    logic  alloc_new;
    logic  do_free;
    logic  do_setq;
    logic  do_clear;
    logic  pend_take;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic match;
    logic cand;
    logic scan_end;
    logic full;
    logic oob;
    logic out_free;
    logic have_pend;
  } stat_t;

endpackage

[design/keyed_slot_allocator_draw_list.sv]
// top level of the keyed slot allocator with draw list builder
//
// channel  | direction | content
// s_axis   | in        | tuser req_type, tdata key, flag, slot index, quad count
// m_axis   | out       | tuser has_command, tdata result fields, tlast last
// cfg      | in        | slot_limit write, taken on any edge with cfg_we_i high
//
// key requests scan slots in order, each slot through a key memory read and then a
// compare; set quad count and clear go from the read state to the response state.
// builds scan the same way and can stall on the result register.
// reset and clear act through per-slot valid bits, no sweep.
// a result waits in the output register; the next request is taken once the
// controller is back in idle.
module keyed_slot_allocator_draw_list #(
  parameter int unsigned SLOTS          = 64,
  parameter int unsigned QUADS_PER_SLOT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coord_x[15:0], coord_y[31:16], coord_z[47:32], transparent[48],
  // slot_sel[56:49], quad_num[72:57], zero fill
  input  logic [79:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], slot[7:2], slot_quads[20:8], slot_transparent[21],
  // index_count[36:22], first_index[57:37], total_commands[64:58], zero fill
  output logic [71:0] m_axis_tdata,
  // has_command[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import ksa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller
  ksa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  ksa_dp #(
    .SLOTS          (SLOTS),
    .QUADS_PER_SLOT (QUADS_PER_SLOT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

[design/ksa_ctrl.sv]
// controller state machine of the keyed slot allocator
module ksa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ksa_pkg::stat_t stat_i,
  output ksa_pkg::cmd_t  cmd_o
);
  import ksa_pkg::*;

  state_e state_q, state_d;
  logic   key_op;
  logic   build_op;

  assign key_op   = (stat_i.req == REQ_ALLOC) || (stat_i.req == REQ_FREE) ||
                    (stat_i.req == REQ_LOOKUP);
  assign build_op = (stat_i.req == REQ_BUILD_OP) || (stat_i.req == REQ_BUILD_TR);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RD;
      end
      S_RD: begin
        if (key_op || build_op) state_d = S_CHK;
        else state_d = S_RESP;
      end
      S_CHK: begin
        if (key_op) begin
          if (stat_i.match) state_d = S_FOUND;
          else if (stat_i.scan_end) state_d = S_MISS;
          else state_d = S_RD;
        end else if (!(stat_i.cand && stat_i.have_pend && !stat_i.out_free)) begin
          state_d = stat_i.scan_end ? S_FLUSH : S_RD;
        end
      end
      S_FOUND: if (stat_i.out_free) state_d = S_IDLE;
      S_MISS: begin
        if (stat_i.req == REQ_ALLOC && !stat_i.full) state_d = S_NEW;
        else if (stat_i.out_free) state_d = S_IDLE;
      end
      S_NEW:   if (stat_i.out_free) state_d = S_IDLE;
      S_RESP:  if (stat_i.out_free) state_d = S_IDLE;
      S_FLUSH: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = EM_EMPTY;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_RD:   cmd_o.rd = 1'b1;
      S_CHK: begin
        if (key_op) begin
          cmd_o.idx_inc = !stat_i.match && !stat_i.scan_end;
        end else if (!(stat_i.cand && stat_i.have_pend && !stat_i.out_free)) begin
          cmd_o.pend_take = stat_i.cand;
          cmd_o.emit      = stat_i.cand && stat_i.have_pend;
          cmd_o.kind      = EM_CMD;
          cmd_o.idx_inc   = !stat_i.scan_end;
        end
      end
      S_FOUND: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.kind      = (stat_i.req == REQ_LOOKUP) ? EM_LOOKUP : EM_FOUND;
        cmd_o.alloc_hit = stat_i.out_free && (stat_i.req == REQ_ALLOC);
        cmd_o.do_free   = stat_i.out_free && (stat_i.req == REQ_FREE);
      end
      S_MISS: begin
        if (stat_i.req == REQ_ALLOC && !stat_i.full) begin
          cmd_o.pop_rd = 1'b1;
        end else begin
          cmd_o.emit = stat_i.out_free;
          cmd_o.kind = (stat_i.req == REQ_ALLOC) ? EM_FULL : EM_NOKEY;
        end
      end
      S_NEW: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.kind      = EM_NEW;
        cmd_o.alloc_new = stat_i.out_free;
      end
      S_RESP: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.req == REQ_SETQ) begin
          cmd_o.kind    = stat_i.oob ? EM_BADIDX : EM_SETQ;
          cmd_o.do_setq = stat_i.out_free && !stat_i.oob;
        end else begin
          cmd_o.do_clear = stat_i.out_free && (stat_i.req == REQ_CLEAR);
        end
      end
      S_FLUSH: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.kind = stat_i.have_pend ? EM_CMD_LAST : EM_EMPTY;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

endmodule

[design/ksa_dp.sv]
// datapath of the keyed slot allocator: slot store, free stack, result register
module ksa_dp #(
  parameter int unsigned SLOTS          = 64,
  parameter int unsigned QUADS_PER_SLOT = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ksa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic [79:0]                in_data_i,
  input  logic [2:0]                 in_user_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [71:0]                out_data_o,
  output logic                       out_user_o,
  output logic                       out_last_o,
  input  ksa_pkg::cmd_t              cmd_i,
  output ksa_pkg::stat_t             stat_o
);
  import ksa_pkg::*;

  localparam int unsigned SW      = $clog2(SLOTS);
  localparam int unsigned QW      = $clog2(QUADS_PER_SLOT + 1);
  localparam int unsigned FI_STEP = QUADS_PER_SLOT * IDX_PER_QUAD;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  // memories
  logic [KEY_W-1:0] key_mem  [SLOTS];
  logic [QW-1:0]    quad_mem [SLOTS];
  logic [SW-1:0]    stk_mem  [SLOTS];

  logic [CNT_W-1:0] limit_q, depth_q, idx_q, total_q;
  logic [SLOTS-1:0] valid_q, transp_q, qwr_q, swr_q;
  logic [SW-1:0]    idx_rd_q, stk_rd_q, stk_ptr_q, pend_slot_q;
  logic [KEY_W-1:0] key_rd_q, key_q;
  logic [QW-1:0]    quad_rd_q, pend_q;
  logic             have_pend_q, tr_q;
  req_e             req_q;
  logic [7:0]       sidx_q;
  logic [15:0]      qc_q;

  logic [QW-1:0]    quad_eff, qc_clamp;
  logic [SW-1:0]    stk_eff, sidx_s;
  logic [CNT_W-1:0] limit_clamp, stk_def;
  logic             want;

  // result register
  logic        out_valid_q;
  logic [1:0]  o_status_q, o_status_d;
  logic [5:0]  o_slot_q, o_slot_d;
  logic [12:0] o_quads_q, o_quads_d;
  logic        o_tr_q, o_tr_d, o_cmd_q, o_cmd_d, o_last_q, o_last_d;
  logic [14:0] o_icnt_q, o_icnt_d;
  logic [20:0] o_first_q, o_first_d;
  logic [6:0]  o_total_q, o_total_d;

  // stored values read through valid bits
  assign quad_eff = qwr_q[idx_rd_q] ? quad_rd_q : '0;
  assign stk_def  = limit_q - CNT_W'(1) - CNT_W'(stk_ptr_q);
  assign stk_eff  = swr_q[stk_ptr_q] ? stk_rd_q : stk_def[SW-1:0];
  assign qc_clamp = (32'(qc_q) < QUADS_PER_SLOT) ? QW'(qc_q) : QW'(QUADS_PER_SLOT);
  assign sidx_s   = sidx_q[SW-1:0];
  assign want     = (req_q == REQ_BUILD_TR);

  always_comb begin
    limit_clamp = cfg_wdata_i;
    if (cfg_wdata_i == '0) limit_clamp = CNT_W'(1);
    else if (cfg_wdata_i > SLOTS_C) limit_clamp = SLOTS_C;
  end

  // status to the controller
  assign stat_o.req       = req_q;
  assign stat_o.match     = valid_q[idx_rd_q] && (key_rd_q == key_q);
  assign stat_o.cand      = valid_q[idx_rd_q] && (quad_eff != '0) &&
                            (transp_q[idx_rd_q] == want);
  assign stat_o.scan_end  = (idx_q == limit_q - CNT_W'(1));
  assign stat_o.full      = (depth_q == '0);
  assign stat_o.oob       = (sidx_q >= {1'b0, limit_q});
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.have_pend = have_pend_q;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      key_rd_q  <= key_mem[idx_q[SW-1:0]];
      quad_rd_q <= quad_mem[idx_q[SW-1:0]];
      idx_rd_q  <= idx_q[SW-1:0];
    end
    if (cmd_i.alloc_new) key_mem[stk_eff] <= key_q;
    if (cmd_i.do_setq) quad_mem[sidx_s] <= qc_clamp;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_rd) begin
      stk_rd_q  <= stk_mem[SW'(depth_q - CNT_W'(1))];
      stk_ptr_q <= SW'(depth_q - CNT_W'(1));
    end
    if (cmd_i.do_free && depth_q < SLOTS_C) stk_mem[depth_q[SW-1:0]] <= idx_rd_q;
  end

  // request capture and build pending command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= in_data_i[47:0];
      tr_q   <= in_data_i[48];
      sidx_q <= in_data_i[56:49];
      qc_q   <= in_data_i[72:57];
      req_q  <= req_e'(in_user_i);
    end
    if (cmd_i.pend_take) begin
      pend_slot_q <= idx_rd_q;
      pend_q      <= quad_eff;
    end
  end

  // control state of the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= SLOTS_C;
      depth_q     <= SLOTS_C;
      idx_q       <= '0;
      total_q     <= '0;
      have_pend_q <= 1'b0;
      valid_q     <= '0;
      transp_q    <= '0;
      qwr_q       <= '0;
      swr_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q       <= '0;
        total_q     <= '0;
        have_pend_q <= 1'b0;
      end
      if (cmd_i.idx_inc) idx_q <= idx_q + CNT_W'(1);
      if (cmd_i.pend_take) begin
        have_pend_q <= 1'b1;
        total_q     <= total_q + CNT_W'(1);
      end
      if (cmd_i.alloc_hit) transp_q[idx_rd_q] <= tr_q;
      if (cmd_i.pop_rd) depth_q <= depth_q - CNT_W'(1);
      if (cmd_i.alloc_new) begin
        valid_q[stk_eff]  <= 1'b1;
        qwr_q[stk_eff]    <= 1'b0;
        transp_q[stk_eff] <= tr_q;
      end
      if (cmd_i.do_free) begin
        valid_q[idx_rd_q] <= 1'b0;
        qwr_q[idx_rd_q]   <= 1'b0;
        if (depth_q < SLOTS_C) begin
          swr_q[depth_q[SW-1:0]] <= 1'b1;
          depth_q                <= depth_q + CNT_W'(1);
        end
      end
      if (cmd_i.do_setq) qwr_q[sidx_s] <= 1'b1;
      if (cmd_i.do_clear) begin
        valid_q  <= '0;
        transp_q <= '0;
        qwr_q    <= '0;
        swr_q    <= '0;
        depth_q  <= limit_q;
      end
      if (cfg_we_i) begin
        limit_q  <= limit_clamp;
        valid_q  <= '0;
        transp_q <= '0;
        qwr_q    <= '0;
        swr_q    <= '0;
        depth_q  <= limit_clamp;
      end
    end
  end

  // result word fields by kind
  always_comb begin
    o_status_d = ST_OK;
    o_slot_d   = '0;
    o_quads_d  = '0;
    o_tr_d     = 1'b0;
    o_cmd_d    = 1'b0;
    o_icnt_d   = '0;
    o_first_d  = '0;
    o_total_d  = '0;
    o_last_d   = 1'b1;
    unique case (cmd_i.kind)
      EM_FOUND:  o_slot_d = 6'(idx_rd_q);
      EM_LOOKUP: begin
        o_slot_d  = 6'(idx_rd_q);
        o_quads_d = 13'(quad_eff);
        o_tr_d    = transp_q[idx_rd_q];
      end
      EM_NEW:    o_slot_d = 6'(stk_eff);
      EM_FULL:   o_status_d = ST_FULL;
      EM_NOKEY:  o_status_d = ST_NOKEY;
      EM_BADIDX: o_status_d = ST_BADIDX;
      EM_SETQ:   o_slot_d = 6'(sidx_s);
      EM_EMPTY:  o_last_d = 1'b1;
      EM_CMD, EM_CMD_LAST: begin
        o_slot_d  = 6'(pend_slot_q);
        o_cmd_d   = 1'b1;
        o_icnt_d  = 15'(32'(pend_q) * IDX_PER_QUAD);
        o_first_d = 21'(32'(pend_slot_q) * FI_STEP);
        o_last_d  = (cmd_i.kind == EM_CMD_LAST);
        o_total_d = (cmd_i.kind == EM_CMD_LAST) ? total_q : '0;
      end
      default:   o_last_d = 1'b1;
    endcase
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_status_q <= o_status_d;
      o_slot_q   <= o_slot_d;
      o_quads_q  <= o_quads_d;
      o_tr_q     <= o_tr_d;
      o_cmd_q    <= o_cmd_d;
      o_icnt_q   <= o_icnt_d;
      o_first_q  <= o_first_d;
      o_total_q  <= o_total_d;
      o_last_q   <= o_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {7'b0, o_total_q, o_first_q, o_icnt_q, o_tr_q, o_quads_q,
                        o_slot_q, o_status_q};
  assign out_user_o  = o_cmd_q;
  assign out_last_o  = o_last_q;

endmodule
